// File: design/categorical_spike_sampler_top_macros.svh
// Assertion helpers for the categorical spike sampler.
`ifndef CATEGORICAL_SPIKE_SAMPLER_TOP_MACROS_SVH
`define CATEGORICAL_SPIKE_SAMPLER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define CSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("css assertion failed");
// Next-cycle implication.
`define CSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("css assertion failed");
`else
`define CSS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/css_pkg.sv
package css_pkg;

  localparam int CSS_PROB_W     = 16;
  localparam int CSS_IDX_W      = 7;
  localparam int CSS_WORD_W     = 32;
  localparam int CSS_SUM_W      = 44;
  localparam int CSS_MAX_VECTOR = 128;
  localparam int CSS_FIFO_DEPTH = 4;

  // Generator constants
  localparam int          TW_DEPTH    = 624;
  localparam int          TW_PTR_W    = $clog2(TW_DEPTH);
  localparam int          TW_SHIFT    = 397;
  localparam logic [31:0] TW_MATRIX   = 32'h9908b0df;
  localparam logic [31:0] TW_UPPER    = 32'h80000000;
  localparam logic [31:0] TW_LOWER    = 32'h7fffffff;
  localparam logic [31:0] TW_TEMPER_B = 32'h9d2c5680;
  localparam logic [31:0] TW_TEMPER_C = 32'hefc60000;
  localparam logic [31:0] TW_SEED_MUL = 32'd69069;
  localparam logic [31:0] SEED_RESET  = 32'd4357;

  typedef struct packed {
    logic [CSS_PROB_W-1:0] probability;
    logic                  last_element;
    logic                  first;
    logic [CSS_IDX_W-1:0]  index;
  } css_item_t;

  typedef struct packed {
    logic need;
    logic take;
  } css_tw_req_t;

  typedef struct packed {
    logic                  valid;
    logic [CSS_WORD_W-1:0] word;
  } css_tw_rsp_t;

  typedef enum logic [2:0] {
    TW_UNSEEDED,
    TW_SEED,
    TW_RD_CUR,
    TW_RD_NXT,
    TW_RD_FAR,
    TW_MIX,
    TW_READY
  } css_tw_state_t;

endpackage

// File: design/css_ifs.sv
interface css_in_if import css_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CSS_PROB_W-1:0] probability;
  logic                  last_element;
  modport source (output valid, probability, last_element, input ready);
  modport sink (input valid, probability, last_element, output ready);
endinterface

interface css_out_if import css_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CSS_IDX_W-1:0] spike_index;
  modport source (output valid, spike_index, input ready);
  modport sink (input valid, spike_index, output ready);
endinterface

interface css_cfg_if import css_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CSS_WORD_W-1:0] seed;
  modport source (output valid, seed, input ready);
  modport sink (input valid, seed, output ready);
endinterface

// File: design/css_front.sv
module css_front import css_pkg::*; #(
  parameter int MAX_VECTOR = CSS_MAX_VECTOR
) (
  input  logic       clk,
  input  logic       rst,
  css_in_if.sink     samples,
  input  logic       full,
  output logic       push,
  output css_item_t  push_item
);

  localparam int CNT_W = $clog2(MAX_VECTOR);

  logic [CNT_W-1:0] count;

  assign samples.ready = !full;
  assign push          = samples.valid && !full;

  always_comb begin
    push_item.probability  = samples.probability;
    push_item.last_element = samples.last_element;
    push_item.first        = (count == '0);
    push_item.index        = CSS_IDX_W'(count);
  end

  // Position within the vector, saturating at the last slot
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      if (samples.last_element) begin
        count <= '0;
      end else if (count < CNT_W'(MAX_VECTOR - 1)) begin
        count <= count + 1'b1;
      end
    end
  end

endmodule

// File: design/css_fifo.sv
module css_fifo import css_pkg::*; #(
  parameter int DEPTH = CSS_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  css_item_t push_item,
  input  logic      pop,
  output css_item_t head,
  output logic      head_valid,
  output logic      full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  css_item_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign head       = slots[rd_ptr];
  assign head_valid = (fill != '0);
  assign full       = (fill == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: design/css_twister.sv
module css_twister import css_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CSS_WORD_W-1:0] seed,
  input  css_tw_req_t           req,
  output css_tw_rsp_t           rsp
);

  css_tw_state_t state, state_next;

  logic [31:0]         words [TW_DEPTH];
  logic [TW_PTR_W-1:0] pos;
  logic [TW_PTR_W-1:0] pos_plus1;
  logic [TW_PTR_W-1:0] far;
  logic [TW_PTR_W:0]   far_sum;
  logic [31:0]         seed_word;
  logic [31:0]         cur;
  logic [31:0]         nxt;
  logic [31:0]         raw;
  logic [31:0]         rd_data;
  logic [31:0]         mixed;
  logic [31:0]         y;
  logic                wr_en;
  logic [TW_PTR_W-1:0] wr_addr;
  logic [31:0]         wr_data;
  logic [TW_PTR_W-1:0] rd_addr;

  function automatic logic [31:0] temper(input logic [31:0] v);
    logic [31:0] t;
    t = v ^ (v >> 11);
    t = t ^ ((t << 7) & TW_TEMPER_B);
    t = t ^ ((t << 15) & TW_TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  assign pos_plus1 = (pos == TW_PTR_W'(TW_DEPTH - 1)) ? '0 : pos + 1'b1;
  assign far_sum   = {1'b0, pos} + (TW_PTR_W + 1)'(TW_SHIFT);
  assign far       = (far_sum >= (TW_PTR_W + 1)'(TW_DEPTH)) ?
                     TW_PTR_W'(far_sum - (TW_PTR_W + 1)'(TW_DEPTH)) :
                     TW_PTR_W'(far_sum);

  // Slots below the current position already hold this round's words
  assign y     = (cur & TW_UPPER) | (nxt & TW_LOWER);
  assign mixed = rd_data ^ (y >> 1) ^ (y[0] ? TW_MATRIX : 32'h0);

  always_comb begin
    state_next = state;
    case (state)
      TW_UNSEEDED: if (req.need) state_next = TW_SEED;
      TW_SEED:     if (pos == TW_PTR_W'(TW_DEPTH - 1)) state_next = TW_RD_CUR;
      TW_RD_CUR:   state_next = TW_RD_NXT;
      TW_RD_NXT:   state_next = TW_RD_FAR;
      TW_RD_FAR:   state_next = TW_MIX;
      TW_MIX:      state_next = TW_READY;
      TW_READY:    if (req.take) state_next = TW_RD_CUR;
      default:     state_next = TW_UNSEEDED;
    endcase
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = pos;
    wr_data   = mixed;
    rd_addr   = pos;
    rsp.valid = 1'b0;
    rsp.word  = temper(raw);
    case (state)
      TW_SEED: begin
        wr_en   = 1'b1;
        wr_data = seed_word;
      end
      TW_RD_CUR: rd_addr = pos;
      TW_RD_NXT: rd_addr = pos_plus1;
      TW_RD_FAR: rd_addr = far;
      TW_MIX:    wr_en = 1'b1;
      TW_READY:  rsp.valid = 1'b1;
      default:   wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      words[wr_addr] <= wr_data;
    end
    rd_data <= words[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TW_UNSEEDED;
      pos   <= '0;
    end else begin
      state <= state_next;
      case (state)
        TW_UNSEEDED: begin
          seed_word <= seed;
          pos       <= '0;
        end
        TW_SEED: begin
          seed_word <= seed_word * TW_SEED_MUL;
          pos       <= pos_plus1;
        end
        TW_RD_NXT: cur <= rd_data;
        TW_RD_FAR: nxt <= rd_data;
        TW_MIX: begin
          raw <= mixed;
          pos <= pos_plus1;
        end
        default: pos <= pos;
      endcase
    end
  end

endmodule

// File: design/css_back.sv
module css_back import css_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  css_item_t   head,
  input  logic        head_valid,
  output logic        pop,
  input  css_tw_rsp_t tw_rsp,
  output css_tw_req_t tw_req,
  css_out_if.source   spikes
);

  logic [CSS_SUM_W-1:0]  running_sum;
  logic [CSS_WORD_W-1:0] threshold;
  logic                  sample_found;
  logic [CSS_IDX_W-1:0]  found_index;
  logic                  out_valid;
  logic [CSS_IDX_W-1:0]  out_index;

  logic [CSS_WORD_W-1:0] thr_cur;
  logic [CSS_SUM_W-1:0]  sum_cur;
  logic                  found_cur;
  logic [CSS_IDX_W-1:0]  findex_cur;
  logic [CSS_SUM_W-1:0]  thr_wide;
  logic [CSS_SUM_W-1:0]  addend;
  logic [CSS_SUM_W-1:0]  sum_add;
  logic [CSS_SUM_W-1:0]  sum_next;
  logic                  found_next;
  logic [CSS_IDX_W-1:0]  findex_next;
  logic                  word_ok;
  logic                  out_free;

  assign spikes.valid       = out_valid;
  assign spikes.spike_index = out_index;

  // A first element waits for its threshold; a last one for the output slot
  assign word_ok  = !head.first || tw_rsp.valid;
  assign out_free = !out_valid || spikes.ready;
  assign pop      = head_valid && word_ok && (!head.last_element || out_free);

  always_comb begin
    tw_req.need = head_valid && head.first && !tw_rsp.valid;
    tw_req.take = pop && head.first;
  end

  always_comb begin
    thr_cur    = head.first ? tw_rsp.word : threshold;
    sum_cur    = head.first ? '0 : running_sum;
    found_cur  = head.first ? 1'b0 : sample_found;
    findex_cur = head.first ? '0 : found_index;
    thr_wide   = {2'b00, thr_cur, 10'b0};
    addend     = {32'b0, 1'b1, head.probability[10:0]} << head.probability[15:11];
    sum_add    = sum_cur + addend;

    sum_next    = sum_cur;
    found_next  = found_cur;
    findex_next = findex_cur;
    if (!found_cur && (sum_cur < thr_wide)) begin
      sum_next = sum_add;
      if ((sum_add >= thr_wide) || head.last_element) begin
        found_next  = 1'b1;
        findex_next = head.index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      threshold   <= thr_cur;
      running_sum <= sum_next;
      found_index <= findex_next;
    end
    if (pop && head.last_element) begin
      out_index <= found_next ? findex_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_found <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        sample_found <= found_next;
      end
      if (pop && head.last_element) begin
        out_valid <= 1'b1;
      end else if (spikes.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: design/categorical_spike_sampler_top.sv
// Categorical spike sampler: inverse-CDF sampling of one index per vector.
// samples: probability elements (16-bit, 5-bit exponent / 11-bit mantissa),
//   last_element marks the end of a vector. One element per cycle while samples.ready is high.
// spikes: one spike_index per vector, offered after its last element.
// seed_cfg: generator seed, always ready; write it while the block is idle.
// Throughput: one element per cycle while the queue has room, but each vector
//   needs a fresh generator word, drawn through the state memory (three reads,
//   one mix/write); the draw overlaps the rest of the vector.
// Result path: a last element passes through the queue and the output
//   register when the word is ready. The first vector after reset also waits
//   for the seeding sweep over all 624 state words, one per cycle, then a draw.
// Reset: seed returns to 4357, the generator returns to unseeded, queues
//   empty. Seeding uses the seed held when the first vector arrives.
// Stall: a held result parks in the output register; elements keep
//   entering the queue until it fills, then samples.ready drops.
`include "categorical_spike_sampler_top_macros.svh"
module categorical_spike_sampler_top import css_pkg::*; #(
  parameter int MAX_VECTOR = CSS_MAX_VECTOR,
  parameter int FIFO_DEPTH = CSS_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  css_in_if.sink    samples,
  css_out_if.source spikes,
  css_cfg_if.sink   seed_cfg
);

  logic [CSS_WORD_W-1:0] seed;
  logic                  push;
  css_item_t             push_item;
  logic                  full;
  css_item_t             head;
  logic                  head_valid;
  logic                  pop;
  css_tw_req_t           tw_req;
  css_tw_rsp_t           tw_rsp;

  // Seed register: always accept writes
  assign seed_cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (seed_cfg.valid) begin
      seed <= seed_cfg.seed;
    end
  end

  // Front: accept, count position, tag first/last
  css_front #(.MAX_VECTOR(MAX_VECTOR)) u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  // Short queue decoupling front from back
  css_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  // Generator: seed once, then prefetch one tempered word at a time
  css_twister u_twister (
    .clk  (clk),
    .rst  (rst),
    .seed (seed),
    .req  (tw_req),
    .rsp  (tw_rsp)
  );

  // Back: accumulate against threshold, hold result for the receiver
  css_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .tw_rsp     (tw_rsp),
    .tw_req     (tw_req),
    .spikes     (spikes)
  );

  // A vector starts only on a ready generator word
  `CSS_ASSERT_IMPL(a_take_has_word, clk, rst, tw_req.take, tw_rsp.valid)
  // A taken word is consumed; the next one needs a fresh draw
  `CSS_ASSERT_NEXT(a_word_consumed, clk, rst, tw_req.take, !tw_rsp.valid)
  // Retiring a last element loads the output register
  `CSS_ASSERT_NEXT(a_last_gives_result, clk, rst, pop && head.last_element, spikes.valid)

endmodule
